>>> sv/fwt_pkg.sv
`default_nettype none
package fwt_pkg;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned CNT_BITS = $clog2(WORD_BITS);

  localparam logic [1:0] V_PRIME   = 2'd0;
  localparam logic [1:0] V_FACTOR  = 2'd1;
  localparam logic [1:0] V_FERMAT  = 2'd2;
  localparam logic [1:0] V_INVALID = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_GCD_STEP,
    OP_MUL_START_SQ,
    OP_MUL_START_X,
    OP_MUL_STEP,
    OP_MUL_DONE,
    OP_NEXT_BIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_eq2;
    logic a_bad;
    logic gcd_done;
    logic gcd_one;
    logic mul_last;
    logic exp_bit;
    logic exp_last;
    logic res_one;
  } stat_t;
endpackage
`default_nettype wire

>>> sv/fwt_if.sv
`default_nettype none
interface fwt_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] candidate;
  logic [63:0] witness_base;
  modport source (output valid, candidate, witness_base, input ready);
  modport sink (input valid, candidate, witness_base, output ready);
endinterface

interface fwt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [63:0] residue;
  modport source (output valid, verdict, residue, input ready);
  modport sink (input valid, verdict, residue, output ready);
endinterface
`default_nettype wire

>>> sv/fwt_datapath.sv
`default_nettype none
module fwt_datapath (
  input  wire logic                          clk_i,
  input  wire fwt_pkg::cmd_t                 cmd_i,
  input  wire logic [63:0]                   cand_i,
  input  wire logic [63:0]                   base_i,
  output fwt_pkg::stat_t                     stat_o,
  output logic [fwt_pkg::WORD_BITS-1:0]      res_o
);
  localparam int unsigned W = fwt_pkg::WORD_BITS;
  localparam int unsigned C = fwt_pkg::CNT_BITS;

  logic [W-1:0] n_q, a_q, r_q, acc_q, x_q, y_q;
  logic [W-1:0] gp_q, gq_q;
  logic [C-1:0] mbit_q, ebit_q;

  // Binary gcd step: halve an even operand, otherwise subtract the smaller
  // odd operand from the larger and halve the difference. Two even operands
  // at the start already share a factor of two.
  logic [W-1:0] g_p_d, g_q_d;
  always_comb begin
    g_p_d = gp_q;
    g_q_d = gq_q;
    if (!gp_q[0]) g_p_d = gp_q >> 1;
    else if (!gq_q[0]) g_q_d = gq_q >> 1;
    else if (gp_q >= gq_q) g_p_d = (gp_q - gq_q) >> 1;
    else g_q_d = (gq_q - gp_q) >> 1;
  end

  function automatic logic [W-1:0] madd(logic [W-1:0] x, logic [W-1:0] y,
                                        logic [W-1:0] n);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[W-1:0];
  endfunction

  logic [W-1:0] dbl;
  logic [W-1:0] nexp;
  assign dbl  = madd(acc_q, acc_q, n_q);
  assign nexp = n_q - W'(1);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      fwt_pkg::OP_LOAD: begin
        n_q    <= cand_i[W-1:0];
        a_q    <= base_i[W-1:0];
        gp_q   <= base_i[W-1:0];
        gq_q   <= cand_i[W-1:0];
        r_q    <= W'(1);
        ebit_q <= C'(W - 1);
      end
      fwt_pkg::OP_GCD_STEP: begin
        gp_q <= g_p_d;
        gq_q <= g_q_d;
      end
      fwt_pkg::OP_MUL_START_SQ: begin
        acc_q  <= '0;
        x_q    <= r_q;
        y_q    <= r_q;
        mbit_q <= C'(W - 1);
      end
      fwt_pkg::OP_MUL_START_X: begin
        acc_q  <= '0;
        x_q    <= a_q;
        y_q    <= r_q;
        mbit_q <= C'(W - 1);
      end
      fwt_pkg::OP_MUL_STEP: begin
        acc_q  <= y_q[mbit_q] ? madd(dbl, x_q, n_q) : dbl;
        mbit_q <= mbit_q - C'(1);
      end
      fwt_pkg::OP_MUL_DONE: r_q <= acc_q;
      fwt_pkg::OP_NEXT_BIT: ebit_q <= ebit_q - C'(1);
      default: ;
    endcase
  end

  assign stat_o.n_lt2    = n_q < W'(2);
  assign stat_o.n_eq2    = n_q == W'(2);
  assign stat_o.a_bad    = (a_q < W'(2)) || (a_q >= n_q);
  assign stat_o.gcd_done = (gp_q == '0) || (!gp_q[0] && !gq_q[0]);
  assign stat_o.gcd_one  = (gp_q == '0) && (gq_q == W'(1));
  assign stat_o.mul_last = mbit_q == '0;
  assign stat_o.exp_bit  = nexp[ebit_q];
  assign stat_o.exp_last = ebit_q == '0;
  assign stat_o.res_one  = r_q == W'(1);
  assign res_o = r_q;
endmodule
`default_nettype wire

>>> sv/fwt_ctrl.sv
`default_nettype none
module fwt_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [1:0]          verdict_o,
  output logic                use_res_o,
  output fwt_pkg::cmd_t       cmd_o,
  input  wire fwt_pkg::stat_t stat_i
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_GCD   = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_MDONE = 4'd5;
  localparam logic [3:0] S_XST   = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       isx_q, isx_d;
  logic [1:0] verd_q, verd_d;
  logic       use_q, use_d;

  // A finished result may be replaced on the same edge it is taken.
  assign in_ready_o  = (state_q == S_IDLE) || (state_q == S_OUT && out_ready_i);
  assign out_valid_o = state_q == S_OUT;
  assign verdict_o   = verd_q;
  assign use_res_o   = use_q;

  always_comb begin
    state_d = state_q;
    isx_d   = isx_q;
    verd_d  = verd_q;
    use_d   = use_q;
    cmd_o.op = fwt_pkg::OP_NONE;
    case (state_q)
      S_IDLE, S_OUT: begin
        if (state_q == S_OUT && out_ready_i) state_d = S_IDLE;
        if (in_valid_i && in_ready_o) begin
          cmd_o.op = fwt_pkg::OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.n_lt2) begin
          verd_d = fwt_pkg::V_INVALID; use_d = 1'b0; state_d = S_OUT;
        end else if (stat_i.n_eq2) begin
          verd_d = fwt_pkg::V_PRIME; use_d = 1'b1; state_d = S_OUT;
        end else if (stat_i.a_bad) begin
          verd_d = fwt_pkg::V_INVALID; use_d = 1'b0; state_d = S_OUT;
        end else state_d = S_GCD;
      end
      S_GCD: begin
        if (stat_i.gcd_done) begin
          if (stat_i.gcd_one) begin
            state_d = S_SQ;
          end else begin
            verd_d = fwt_pkg::V_FACTOR; use_d = 1'b0; state_d = S_OUT;
          end
        end else cmd_o.op = fwt_pkg::OP_GCD_STEP;
      end
      S_SQ: begin
        cmd_o.op = fwt_pkg::OP_MUL_START_SQ;
        isx_d = 1'b0;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = fwt_pkg::OP_MUL_STEP;
        if (stat_i.mul_last) state_d = S_MDONE;
      end
      S_MDONE: begin
        cmd_o.op = fwt_pkg::OP_MUL_DONE;
        if (!isx_q && stat_i.exp_bit) state_d = S_XST;
        else state_d = S_NEXT;
      end
      S_XST: begin
        // The base product starts once the square has been written back.
        cmd_o.op = fwt_pkg::OP_MUL_START_X;
        isx_d = 1'b1;
        state_d = S_MUL;
      end
      S_NEXT: begin
        if (stat_i.exp_last) begin
          verd_d = stat_i.res_one ? fwt_pkg::V_PRIME : fwt_pkg::V_FERMAT;
          use_d = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.op = fwt_pkg::OP_NEXT_BIT;
          state_d = S_SQ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      isx_q   <= 1'b0;
      verd_q  <= fwt_pkg::V_PRIME;
      use_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      isx_q   <= isx_d;
      verd_q  <= verd_d;
      use_q   <= use_d;
    end
  end
endmodule
`default_nettype wire

>>> sv/fermat_witness_test_top.sv
`default_nettype none
// Fermat witness test.
// One input beat carries a candidate n and a witness base a; one output beat
// returns a verdict (probable prime, common factor, Fermat failure, invalid)
// and the residue a^(n-1) mod n. Both channels are valid/ready.
// A candidate below three or a base out of range is settled in the check
// state, which passes straight to the output state. Otherwise a binary gcd
// runs one step per cycle. Then square-and-multiply walks the 64 exponent
// bits. Each bit costs one square (a start, add-and-double steps over the
// multiplier bits and a write-back), one more such multiply when the bit is
// set, and a step on to the next bit.
// One item is in work at a time. A finished result waits in the output
// register while the receiver stalls, and no input beat is taken meanwhile;
// the next input beat can be taken in the same cycle as the result beat.
// Reset empties the block: no result pending, input ready high.
module fermat_witness_test_top (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  fwt_in_if.sink    in_if,
  fwt_out_if.source out_if
);
  fwt_pkg::cmd_t  cmd;
  fwt_pkg::stat_t stat;
  logic [fwt_pkg::WORD_BITS-1:0] res;
  logic use_res;
  logic [1:0] verdict;

  // The controller sequences the test; the datapath holds all operands.
  fwt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .verdict_o(verdict), .use_res_o(use_res),
    .cmd_o(cmd), .stat_i(stat)
  );

  fwt_datapath u_dp (
    .clk_i, .cmd_i(cmd),
    .cand_i(in_if.candidate), .base_i(in_if.witness_base),
    .stat_o(stat), .res_o(res)
  );

  // Invalid and common-factor verdicts report a zero residue; the others report the result register.
  assign out_if.verdict = verdict;
  assign out_if.residue = use_res ? 64'(res) : 64'd0;

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !out_if.valid || out_if.ready)
    else $error("input taken while a result waits");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.verdict))
    else $error("result lost");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> $stable(out_if.residue))
    else $error("residue changed");
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.verdict == fwt_pkg::V_PRIME
      |-> out_if.residue == 64'd1)
    else $error("prime residue");
endmodule
`default_nettype wire
